/* src/deq_pkg.sv */
`default_nettype none
package deq_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  localparam int CMD_W   = 3;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 11;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;

  localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

  // Commands from the controller to the datapath, one step each
  typedef struct packed {
    logic capture;   // register the accepted transaction
    logic exec;      // update pointers, write or read the slot memory
    logic load;      // settle front/back, fill the output register
  } deq_ctl_t;

endpackage
`default_nettype wire

/* src/deq_ctrl.sv */
`default_nettype none
module deq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output deq_pkg::deq_ctl_t    ctl
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    ctl.capture = (state == S_IDLE) && in_valid;
    ctl.exec    = (state == S_EXEC);
    ctl.load    = (state == S_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // raise valid with a fresh result, drop it once taken
      if (ctl.load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          // hold until the output register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/deq_datapath.sv */
`default_nettype none
module deq_datapath #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire deq_pkg::deq_ctl_t              ctl,
  input  wire logic [deq_pkg::CMD_W-1:0]      cmd,
  input  wire logic signed [deq_pkg::DATA_W-1:0] push_value,
  output logic signed [deq_pkg::DATA_W-1:0]   popped_value,
  output logic signed [deq_pkg::DATA_W-1:0]   front_value,
  output logic signed [deq_pkg::DATA_W-1:0]   back_value,
  output logic [deq_pkg::COUNT_W-1:0]         count,
  output logic                                queue_empty,
  output logic                                overflow
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DepthWide = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthCnt  = CW'(DEPTH);
  localparam logic [AW-1:0] LastIdx   = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DepthWide) begin
      s = s - DepthWide;
    end
    return s[AW-1:0];
  endfunction

  logic [DATA_W-1:0] slots [DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] val_q;
  logic [AW-1:0]     head;
  logic [CW-1:0]     cnt;
  logic [DATA_W-1:0] front;
  logic [DATA_W-1:0] back;
  logic [DATA_W-1:0] popped;
  logic              ovf;
  logic              fix_front;
  logic              fix_back;

  logic [AW-1:0]     head_next;
  logic [CW-1:0]     cnt_next;
  logic [DATA_W-1:0] front_next;
  logic [DATA_W-1:0] back_next;
  logic [DATA_W-1:0] popped_next;
  logic              ovf_next;
  logic              fix_front_next;
  logic              fix_back_next;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] front_fix;
  logic [DATA_W-1:0] back_fix;

  always_comb begin
    head_next      = head;
    cnt_next       = cnt;
    front_next     = front;
    back_next      = back;
    popped_next    = EMPTY_MARK;
    ovf_next       = 1'b0;
    fix_front_next = 1'b0;
    fix_back_next  = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = ring_add(head, AW'(cnt));
    rd_en          = 1'b0;
    rd_addr        = ring_add(head, AW'(1));
    case (cmd_q)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (cnt == DepthCnt) begin
          ovf_next = 1'b1;
        end else begin
          wr_en    = 1'b1;
          cnt_next = cnt + CW'(1);
          if (cmd_q == CMD_PUSH_FRONT) begin
            head_next  = (head == '0) ? LastIdx : head - AW'(1);
            wr_addr    = head_next;
            front_next = val_q;
            if (cnt == '0) begin
              back_next = val_q;
            end
          end else begin
            back_next = val_q;
            if (cnt == '0) begin
              front_next = val_q;
            end
          end
        end
      end
      CMD_POP_FRONT: begin
        if (cnt != '0) begin
          popped_next = front;
          head_next   = ring_add(head, AW'(1));
          cnt_next    = cnt - CW'(1);
          if (cnt == CW'(2)) begin
            front_next = back;
          end else if (cnt > CW'(2)) begin
            rd_en          = 1'b1;
            fix_front_next = 1'b1;
          end
        end
      end
      CMD_POP_BACK: begin
        if (cnt != '0) begin
          popped_next = back;
          cnt_next    = cnt - CW'(1);
          rd_addr     = ring_add(head, AW'(cnt - CW'(2)));
          if (cnt == CW'(2)) begin
            back_next = front;
          end else if (cnt > CW'(2)) begin
            rd_en         = 1'b1;
            fix_back_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign front_fix = fix_front ? rd_data : front;
  assign back_fix  = fix_back ? rd_data : back;

  always_ff @(posedge clk) begin
    if (wr_en && ctl.exec) begin
      slots[wr_addr] <= val_q;
    end
    if (rd_en && ctl.exec) begin
      rd_data <= slots[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      cnt       <= '0;
      fix_front <= 1'b0;
      fix_back  <= 1'b0;
    end else begin
      if (ctl.exec) begin
        head      <= head_next;
        cnt       <= cnt_next;
        fix_front <= fix_front_next;
        fix_back  <= fix_back_next;
      end else if (ctl.load) begin
        fix_front <= 1'b0;
        fix_back  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= cmd;
      val_q <= push_value;
    end
    if (ctl.exec) begin
      front  <= front_next;
      back   <= back_next;
      popped <= popped_next;
      ovf    <= ovf_next;
    end else if (ctl.load) begin
      front <= front_fix;
      back  <= back_fix;
    end
    if (ctl.load) begin
      popped_value <= $signed(popped);
      front_value  <= $signed((cnt == '0) ? EMPTY_MARK : front_fix);
      back_value   <= $signed((cnt == '0) ? EMPTY_MARK : back_fix);
      count        <= COUNT_W'(cnt);
      queue_empty  <= (cnt == '0);
      overflow     <= ovf;
    end
  end

endmodule
`default_nettype wire

/* src/double_ended_queue_unit.sv */
`default_nettype none
// Double-ended queue of signed 32-bit values held in a ring buffer of DEPTH
// slots (default 1024). Each input transaction carries a command (push front,
// push back, pop front, pop back, or peek; unused codes peek) and a value used
// only by pushes. Each transaction yields exactly one result: the popped value
// (-1 for an empty queue or a non-pop), the front and back values after the
// step (-1 when empty), the element count, an empty flag and an overflow flag
// set when a push met a full queue and was dropped. The queue is empty after
// reset and needs no clearing pass. A transaction passes through capture,
// slot memory write or read, and settle and load of the result; the input
// register plus the registered slot read that a pop needs set these steps,
// and a new transaction is not taken until the previous one has left the
// settle step. The result sits in an output register, so the next
// transaction is accepted while an earlier result is still stalled
// downstream; that one then holds in the settle step until the output
// register is free. Front and back are kept in registers, so each step
// touches at most one slot.
module double_ended_queue_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [deq_pkg::CMD_W-1:0]         cmd,
  input  wire logic signed [deq_pkg::DATA_W-1:0] push_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [deq_pkg::DATA_W-1:0]      popped_value,
  output logic signed [deq_pkg::DATA_W-1:0]      front_value,
  output logic signed [deq_pkg::DATA_W-1:0]      back_value,
  output logic [deq_pkg::COUNT_W-1:0]            count,
  output logic                                   queue_empty,
  output logic                                   overflow
);
  import deq_pkg::*;

  deq_ctl_t ctl;

  // Sequence each transaction: capture, execute, load the result
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Ring pointers, front/back registers, slot memory and output register
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cmd          (cmd),
    .push_value   (push_value),
    .popped_value (popped_value),
    .front_value  (front_value),
    .back_value   (back_value),
    .count        (count),
    .queue_empty  (queue_empty),
    .overflow     (overflow)
  );

endmodule
`default_nettype wire

/* src/deq_checker.sv */
`default_nettype none
module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [deq_pkg::DATA_W-1:0] popped_value,
  input wire logic signed [deq_pkg::DATA_W-1:0] front_value,
  input wire logic signed [deq_pkg::DATA_W-1:0] back_value,
  input wire logic [deq_pkg::COUNT_W-1:0]       count,
  input wire logic                              queue_empty,
  input wire logic                              overflow
);
  import deq_pkg::*;

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (queue_empty == (count == '0)))
    else $error("queue_empty disagrees with count");

  // An empty queue shows no front or back element
  a_empty_marks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queue_empty) |->
      (front_value == -32'sd1 && back_value == -32'sd1))
    else $error("empty queue shows an element");

  // A dropped push pops nothing and leaves the queue full
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |->
      (popped_value == -32'sd1 && count == COUNT_W'(DEPTH)))
    else $error("overflow result inconsistent");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(count) && $stable(popped_value)))
    else $error("stalled result changed");

  // A transaction taken now cannot be followed by another in the next cycle
  a_spacing: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("back-to-back acceptance");

endmodule

bind double_ended_queue_unit deq_checker #(
  .DEPTH (DEPTH)
) u_deq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .popped_value (popped_value),
  .front_value  (front_value),
  .back_value   (back_value),
  .count        (count),
  .queue_empty  (queue_empty),
  .overflow     (overflow)
);
`default_nettype wire
